// ===== sv/ipdd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipdd_pkg
// shared widths, register indexes, reset values and types of the
// pulse-distance infrared frame decoder
// ----------------------------------------------------------------------------
package ipdd_pkg;

    localparam int IntervalW = 16;
    localparam int CfgDataW  = 16;
    localparam int CfgAddrW  = 3;
    localparam int FrameW    = 32;
    localparam int ByteW     = 8;

    localparam int FrameBitsDefault = 32;

    // register indexes on the configuration channel
    localparam logic [CfgAddrW-1:0] CfgLeaderMin = 3'd0;
    localparam logic [CfgAddrW-1:0] CfgLeaderMax = 3'd1;
    localparam logic [CfgAddrW-1:0] CfgOneMin    = 3'd2;
    localparam logic [CfgAddrW-1:0] CfgOneMax    = 3'd3;
    localparam logic [CfgAddrW-1:0] CfgZeroMin   = 3'd4;
    localparam logic [CfgAddrW-1:0] CfgZeroMax   = 3'd5;

    localparam logic [CfgDataW-1:0] LeaderMinRst = 16'd1300;
    localparam logic [CfgDataW-1:0] LeaderMaxRst = 16'd1400;
    localparam logic [CfgDataW-1:0] OneMinRst    = 16'd220;
    localparam logic [CfgDataW-1:0] OneMaxRst    = 16'd230;
    localparam logic [CfgDataW-1:0] ZeroMinRst   = 16'd105;
    localparam logic [CfgDataW-1:0] ZeroMaxRst   = 16'd120;

    typedef struct packed {
        logic [CfgDataW-1:0] leader_min;
        logic [CfgDataW-1:0] leader_max;
        logic [CfgDataW-1:0] one_min;
        logic [CfgDataW-1:0] one_max;
        logic [CfgDataW-1:0] zero_min;
        logic [CfgDataW-1:0] zero_max;
    } t_windows;

    typedef struct packed {
        logic leader;
        logic one;
        logic zero;
    } t_match;

endpackage
`default_nettype wire

// ===== sv/ipdd_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipdd channel interfaces
// valid/ready channels for intervals, decoded results and register writes
// ----------------------------------------------------------------------------
interface ipdd_in_if;
    logic                           valid;
    logic                           ready;
    logic [ipdd_pkg::IntervalW-1:0] interval;

    modport source (output valid, output interval, input ready);
    modport sink   (input valid, input interval, output ready);
endinterface

interface ipdd_out_if;
    logic                       valid;
    logic                       ready;
    logic                       frame_done;
    logic [ipdd_pkg::ByteW-1:0] command;
    logic                       command_valid;
    logic [ipdd_pkg::ByteW-1:0] address;

    modport source (output valid, output frame_done, output command,
                    output command_valid, output address, input ready);
    modport sink   (input valid, input frame_done, input command,
                    input command_valid, input address, output ready);
endinterface

interface ipdd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ipdd_pkg::CfgAddrW-1:0] addr;
    logic [ipdd_pkg::CfgDataW-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/ipdd_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipdd_cfg_regs
// window bound registers, written over the configuration channel
// ----------------------------------------------------------------------------
module ipdd_cfg_regs (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    ipdd_cfg_if.sink          i_cfg,
    output ipdd_pkg::t_windows o_windows
);

    ipdd_pkg::t_windows r_windows;
    logic               w_wr;

    assign i_cfg.ready = 1'b1;
    assign w_wr        = i_cfg.valid;
    assign o_windows   = r_windows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_windows.leader_min <= ipdd_pkg::LeaderMinRst;
            r_windows.leader_max <= ipdd_pkg::LeaderMaxRst;
            r_windows.one_min    <= ipdd_pkg::OneMinRst;
            r_windows.one_max    <= ipdd_pkg::OneMaxRst;
            r_windows.zero_min   <= ipdd_pkg::ZeroMinRst;
            r_windows.zero_max   <= ipdd_pkg::ZeroMaxRst;
        end else if (w_wr) begin
            unique case (i_cfg.addr)
                ipdd_pkg::CfgLeaderMin: r_windows.leader_min <= i_cfg.data;
                ipdd_pkg::CfgLeaderMax: r_windows.leader_max <= i_cfg.data;
                ipdd_pkg::CfgOneMin:    r_windows.one_min    <= i_cfg.data;
                ipdd_pkg::CfgOneMax:    r_windows.one_max    <= i_cfg.data;
                ipdd_pkg::CfgZeroMin:   r_windows.zero_min   <= i_cfg.data;
                ipdd_pkg::CfgZeroMax:   r_windows.zero_max   <= i_cfg.data;
                default: begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== sv/ipdd_window_cmp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipdd_window_cmp
// classifies one interval against the leader, one and zero windows
// ----------------------------------------------------------------------------
module ipdd_window_cmp (
    input  wire logic [ipdd_pkg::IntervalW-1:0] i_interval,
    input  wire ipdd_pkg::t_windows             i_windows,
    output ipdd_pkg::t_match                    o_match
);

    // bounds are exclusive, an empty or inverted window never matches
    always_comb begin
        o_match.leader = (i_interval > i_windows.leader_min) &&
                         (i_interval < i_windows.leader_max);
        o_match.one    = (i_interval > i_windows.one_min) &&
                         (i_interval < i_windows.one_max);
        o_match.zero   = (i_interval > i_windows.zero_min) &&
                         (i_interval < i_windows.zero_max);
    end

endmodule
`default_nettype wire

// ===== sv/ipdd_frame_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipdd_frame_core
// frame shift register, arm flag and bit counter, plus the result register
// ----------------------------------------------------------------------------
module ipdd_frame_core #(
    parameter int FRAME_BITS = ipdd_pkg::FrameBitsDefault
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_adv,
    input  wire ipdd_pkg::t_match           i_match,
    output logic                            o_frame_done,
    output logic [ipdd_pkg::ByteW-1:0]      o_command,
    output logic                            o_command_valid,
    output logic [ipdd_pkg::ByteW-1:0]      o_address
);

    localparam int CntW = $clog2(FRAME_BITS + 1);

    logic [ipdd_pkg::FrameW-1:0] r_shift;
    logic [ipdd_pkg::FrameW-1:0] n_shift;
    logic                        r_armed;
    logic                        n_armed;
    logic [CntW-1:0]             r_count;
    logic [CntW-1:0]             n_count;
    logic                        n_done;
    logic                        w_take;

    logic                        r_frame_done;
    logic [ipdd_pkg::ByteW-1:0]  r_command;
    logic                        r_command_valid;
    logic [ipdd_pkg::ByteW-1:0]  r_address;

    assign w_take = !i_match.leader && r_armed && (i_match.one || i_match.zero);

    always_comb begin
        n_shift = r_shift;
        n_armed = r_armed;
        n_count = r_count;
        n_done  = 1'b0;
        priority if (i_match.leader) begin
            // leader rearms, frame bits are kept
            n_armed = 1'b1;
            n_count = '0;
        end else if (w_take) begin
            n_shift = {i_match.one, r_shift[ipdd_pkg::FrameW-1:1]};
            n_count = r_count + CntW'(1);
            if (n_count == CntW'(FRAME_BITS)) begin
                n_done  = 1'b1;
                n_armed = 1'b0;
                n_count = '0;
            end
        end else begin
            // not armed or no window matched, state holds
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
            r_armed <= 1'b0;
            r_count <= '0;
        end else if (i_adv) begin
            r_shift <= n_shift;
            r_armed <= n_armed;
            r_count <= n_count;
        end
    end

    // result fields read fixed bit positions and are zero without a frame
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_frame_done    <= n_done;
            r_command       <= n_done ? n_shift[23:16] : '0;
            r_command_valid <= n_done && (n_shift[23:16] == ~n_shift[31:24]);
            r_address       <= n_done ? n_shift[7:0] : '0;
        end
    end

    assign o_frame_done    = r_frame_done;
    assign o_command       = r_command;
    assign o_command_valid = r_command_valid;
    assign o_address       = r_address;

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < CntW'(FRAME_BITS))
        else $error("bit count reached frame length");

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_armed |-> r_count == '0)
        else $error("bit count nonzero while disarmed");

    a_done_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && n_done) |=> (!r_armed && r_frame_done))
        else $error("finished frame did not disarm");

    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_adv) && !r_frame_done |->
            (r_command == '0 && !r_command_valid && r_address == '0))
        else $error("result fields set without a finished frame");
`endif

endmodule
`default_nettype wire

// ===== sv/ir_pulse_distance_decoder_core.sv =====
// data path: an accepted interval is registered in the interval register, and its
// result is registered in the result register once the result slot is free
// throughput: one interval per cycle; a stalled result holds both stages
// reset: synchronous active-low i_rst_n clears both stages, disarms the
// decoder, empties the frame and reloads the default window bounds
`default_nettype none
// ----------------------------------------------------------------------------
// ir_pulse_distance_decoder_core
// pulse-distance infrared frame decoder: interval register, window compare,
// frame state update and result register
// ----------------------------------------------------------------------------
module ir_pulse_distance_decoder_core #(
    parameter int FRAME_BITS = ipdd_pkg::FrameBitsDefault
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ipdd_in_if.sink   i_in,
    ipdd_cfg_if.sink  i_cfg,
    ipdd_out_if.source o_out
);

    logic                           r_in_valid;
    logic [ipdd_pkg::IntervalW-1:0] r_interval;
    logic                           r_out_valid;
    logic                           w_out_free;
    logic                           w_adv;
    ipdd_pkg::t_windows             w_windows;
    ipdd_pkg::t_match               w_match;

    // result slot is free when empty or being taken this cycle
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_adv      = r_in_valid && w_out_free;
    assign i_in.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_interval <= i_in.interval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_adv;
        end
    end

    ipdd_cfg_regs u_cfg_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .o_windows (w_windows)
    );

    ipdd_window_cmp u_window_cmp (
        .i_interval (r_interval),
        .i_windows  (w_windows),
        .o_match    (w_match)
    );

    ipdd_frame_core #(
        .FRAME_BITS (FRAME_BITS)
    ) u_frame_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (w_adv),
        .i_match         (w_match),
        .o_frame_done    (o_out.frame_done),
        .o_command       (o_out.command),
        .o_command_valid (o_out.command_valid),
        .o_address       (o_out.address)
    );

    assign o_out.valid = r_out_valid;

endmodule
`default_nettype wire
